/* rtl/smon_pkg.sv */
`timescale 1ns / 1ps
package smon_pkg;

	// Ring geometry
	localparam int RING_DEPTH = 256;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	// Percentile rank: floor(x / 100) as (x * RECIP) >> RECIP_SHIFT
	localparam int RANK_PROD_W  = CNT_W + 7;
	localparam int RECIP_SHIFT  = 26;
	localparam int RECIP_W      = 20;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SHIFT + 99) / 100);
	localparam logic [6:0] PCT_TAB [4] = '{7'd50, 7'd95, 7'd99, 7'd100};

	// Rate: received * 256 * 10^6 / elapsed
	localparam int NUM_W   = 60;
	localparam int DCNT_W  = $clog2(NUM_W);
	localparam logic [27:0] RATE_SCALE = 28'd256000000;

	localparam logic [31:0] GAP_LIMIT = 32'h8000_0000;
	localparam logic [31:0] FULL32    = 32'hFFFF_FFFF;

	// Opcodes
	localparam logic [1:0] OP_ACCEPT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_RANK,
		ST_SEL_GO,
		ST_SEL_WAIT,
		ST_DONE
	} smon_state_t;

	typedef enum logic [1:0] {
		SEL_IDLE,
		SEL_SCAN,
		SEL_DRAIN,
		SEL_UPDATE
	} smon_sel_state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] sequence_number;
		logic [63:0] time_us;
	} smon_req_t;

	typedef struct packed {
		logic [31:0] received_count;
		logic [31:0] dropped_count;
		logic        sequence_seen;
		logic [31:0] last_sequence_number;
		logic        rate_valid;
		logic [31:0] rate_hz_q8;
		logic        intervals_valid;
		logic [31:0] median_interval_us;
		logic [31:0] p95_interval_us;
		logic [31:0] p99_interval_us;
		logic [31:0] max_interval_us;
	} smon_rsp_t;

	typedef struct packed {
		logic             start;
		logic [IDX_W-1:0] rank;
		logic [CNT_W-1:0] count;
	} smon_sel_cmd_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} smon_sel_sts_t;

endpackage

/* rtl/smon_req_if.sv */
`timescale 1ns / 1ps
interface smon_req_if;
	import smon_pkg::*;
	logic      valid;
	logic      ready;
	smon_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/smon_rsp_if.sv */
`timescale 1ns / 1ps
interface smon_rsp_if;
	import smon_pkg::*;
	logic      valid;
	logic      ready;
	smon_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/stream_gap_and_jitter_monitor.sv */
`timescale 1ns / 1ps
// Stream gap and jitter monitor.
// req carries one beat per operation: opcode, sequence_number, time_us.
//   accept: counts the packet, adds sequence gaps to the drop count and
//   stores the inter-arrival interval in a 256-entry ring.
//   clear: returns all statistics to their reset values.
//   query: produces one rsp beat with counters, last sequence, rate in
//   Q24.8 Hz and the 50/95/99 percentile and maximum stored intervals.
// A query holds req.ready low until its result is loaded for rsp: the rate
// goes through a bit-serial divider (60 steps, skipped when no rate is
// due), and each percentile is a radix select that sweeps the ring memory
// once per result bit through its single read port; with no intervals the
// selects are skipped.
// Accepts and clears are taken while a finished response still waits on
// rsp; a later query holds its result until rsp is free.
// Reset (arst_n low) clears all counters and flags; the ring needs no
// clearing pass since only entries written since the last clear are read.
// A stalled rsp holds its beat unchanged until rsp.ready.
module stream_gap_and_jitter_monitor (
	input  logic        clk,
	input  logic        arst_n,
	smon_req_if.sink    req,
	smon_rsp_if.source  rsp
);
	import smon_pkg::*;

	smon_state_t state_q, state_d;

	logic [31:0]      prev_seq_q;
	logic             seq_seen_q;
	logic [63:0]      prev_time_q;
	logic             time_seen_q;
	logic [63:0]      win_start_q;
	logic [IDX_W-1:0] cursor_q;
	logic [CNT_W-1:0] fill_q;
	logic [31:0]      rcv_q;
	logic [31:0]      drop_q;

	logic [63:0]            elapsed_q;
	logic                   rate_ok_q;
	logic [NUM_W-1:0]       num_q;
	logic [1:0]             p_q;
	logic [RANK_PROD_W-1:0] rank_prod_q;
	smon_rsp_t              res_q;
	smon_rsp_t              rsp_q;
	logic                   rsp_valid_q;

	logic                          fire;
	logic [31:0]                   seq_dist;
	logic [32:0]                   drop_sum;
	logic [63:0]                   tdiff;
	logic [31:0]                   iv;
	logic                          wr_en;
	logic [CNT_W-1:0]              fill_m1;
	logic [RANK_PROD_W+RECIP_W-1:0] rank_full;
	logic                          div_start;
	logic                          div_done;
	logic [31:0]                   div_quo;
	smon_sel_cmd_t                 sel_cmd;
	smon_sel_sts_t                 sel_sts;
	smon_state_t                   after_rate;

	// Accept-path arithmetic
	always_comb begin
		fire      = req.valid && req.ready;
		seq_dist  = req.data.sequence_number - prev_seq_q;
		drop_sum  = {1'b0, drop_q} + {1'b0, seq_dist - 32'd1};
		tdiff     = (req.data.time_us >= prev_time_q) ? (req.data.time_us - prev_time_q) : '0;
		iv        = (|tdiff[63:32]) ? FULL32 : tdiff[31:0];
		wr_en     = fire && (req.data.opcode == OP_ACCEPT) && time_seen_q;
		fill_m1   = fill_q - CNT_W'(1);
		rank_full = RANK_PROD_W'(rank_prod_q) * (RANK_PROD_W+RECIP_W)'(RECIP);
		after_rate = (fill_q == '0) ? ST_DONE : ST_RANK;
	end

	// Next state of the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (fire && req.data.opcode == OP_QUERY) state_d = ST_MUL;
			ST_MUL:      state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = rate_ok_q ? ST_DIV_WAIT : after_rate;
			ST_DIV_WAIT: if (div_done) state_d = after_rate;
			ST_RANK:     state_d = ST_SEL_GO;
			ST_SEL_GO:   state_d = ST_SEL_WAIT;
			ST_SEL_WAIT: if (sel_sts.done) state_d = (p_q == 2'd3) ? ST_DONE : ST_RANK;
			ST_DONE:     if (!rsp_valid_q) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req.ready     = (state_q == ST_IDLE);
		div_start     = (state_q == ST_DIV_GO) && rate_ok_q;
		sel_cmd.start = (state_q == ST_SEL_GO);
		sel_cmd.rank  = rank_full[RECIP_SHIFT +: IDX_W];
		sel_cmd.count = fill_q;
		rsp.valid     = rsp_valid_q;
		rsp.data      = rsp_q;
	end

	// Statistics state and query working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_seq_q  <= '0;
			seq_seen_q  <= 1'b0;
			prev_time_q <= '0;
			time_seen_q <= 1'b0;
			win_start_q <= '0;
			cursor_q    <= '0;
			fill_q      <= '0;
			rcv_q       <= '0;
			drop_q      <= '0;
			elapsed_q   <= '0;
			rate_ok_q   <= 1'b0;
			num_q       <= '0;
			p_q         <= '0;
			rank_prod_q <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (fire) begin
						case (req.data.opcode)
							OP_ACCEPT: begin
								if (seq_seen_q && seq_dist > 32'd1 && seq_dist < GAP_LIMIT) begin
									drop_q <= drop_sum[32] ? FULL32 : drop_sum[31:0];
								end
								prev_seq_q <= req.data.sequence_number;
								seq_seen_q <= 1'b1;
								if (time_seen_q) begin
									cursor_q <= (cursor_q == IDX_W'(RING_DEPTH - 1)) ?
										'0 : cursor_q + 1'b1;
									if (fill_q != CNT_W'(RING_DEPTH)) begin
										fill_q <= fill_q + 1'b1;
									end
								end else begin
									time_seen_q <= 1'b1;
									win_start_q <= req.data.time_us;
								end
								prev_time_q <= req.data.time_us;
								if (rcv_q != FULL32) begin
									rcv_q <= rcv_q + 32'd1;
								end
							end
							OP_QUERY: begin
								elapsed_q <= req.data.time_us - win_start_q;
								rate_ok_q <= time_seen_q && (req.data.time_us > win_start_q);
								p_q       <= '0;
								res_q     <= {rcv_q, drop_q, seq_seen_q, prev_seq_q, 1'b0, 32'd0,
									(fill_q != '0), 128'd0};
							end
							OP_CLEAR: begin
								prev_seq_q  <= '0;
								seq_seen_q  <= 1'b0;
								prev_time_q <= '0;
								time_seen_q <= 1'b0;
								win_start_q <= '0;
								cursor_q    <= '0;
								fill_q      <= '0;
								rcv_q       <= '0;
								drop_q      <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					num_q <= NUM_W'(rcv_q) * NUM_W'(RATE_SCALE);
				end
				ST_DIV_GO: begin
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						res_q.rate_valid <= 1'b1;
						res_q.rate_hz_q8 <= div_quo;
					end
				end
				ST_RANK: begin
					rank_prod_q <= RANK_PROD_W'(fill_m1) * RANK_PROD_W'(PCT_TAB[p_q]);
				end
				ST_SEL_GO: begin
				end
				ST_SEL_WAIT: begin
					if (sel_sts.done) begin
						case (p_q)
							2'd0:    res_q.median_interval_us <= sel_sts.value;
							2'd1:    res_q.p95_interval_us    <= sel_sts.value;
							2'd2:    res_q.p99_interval_us    <= sel_sts.value;
							default: res_q.max_interval_us    <= sel_sts.value;
						endcase
						p_q <= p_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	smon_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (elapsed_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	smon_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (cursor_q),
		.wr_data (iv),
		.sel_cmd (sel_cmd),
		.sel_sts (sel_sts)
	);

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(RING_DEPTH))
		else $error("ring fill above depth");

	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.rate_valid |-> rsp_q.rate_hz_q8 == '0)
		else $error("rate nonzero while not valid");

	a_iv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.intervals_valid |-> rsp_q.max_interval_us == '0)
		else $error("interval nonzero while none stored");

	a_iv_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.median_interval_us <= rsp_q.p95_interval_us) &&
			(rsp_q.p95_interval_us <= rsp_q.p99_interval_us) &&
			(rsp_q.p99_interval_us <= rsp_q.max_interval_us))
		else $error("percentiles out of order");
`endif

endmodule

/* rtl/smon_div.sv */
`timescale 1ns / 1ps
module smon_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [smon_pkg::NUM_W-1:0] dividend,
	input  logic [63:0]               divisor,
	output logic                      done,
	output logic [31:0]               quotient
);
	import smon_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [63:0]       rem_q;
	logic [63:0]       den_q;
	logic [64:0]       trial;
	logic [64:0]       diff;
	logic              ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// Advance one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(NUM_W - 1);
				num_q  <= dividend;
				den_q  <= divisor;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				rem_q <= ge ? diff[63:0] : trial[63:0];
				quo_q <= {quo_q[NUM_W-2:0], ge};
				num_q <= {num_q[NUM_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Saturate to 32 bits
	assign done     = done_q;
	assign quotient = (|quo_q[NUM_W-1:32]) ? FULL32 : quo_q[31:0];

endmodule

/* rtl/smon_ring.sv */
`timescale 1ns / 1ps
module smon_ring (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [smon_pkg::IDX_W-1:0]  wr_addr,
	input  logic [31:0]                 wr_data,
	input  smon_pkg::smon_sel_cmd_t     sel_cmd,
	output smon_pkg::smon_sel_sts_t     sel_sts
);
	import smon_pkg::*;

	logic [31:0] mem [RING_DEPTH];

	smon_sel_state_t  state_q, state_d;
	logic [4:0]       bit_q;
	logic [IDX_W-1:0] addr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] k_q;
	logic [31:0]      pfx_q;
	logic             done_q;
	logic             vld_s1;
	logic [31:0]      rd_s1;
	logic [31:0]      hi_mask;
	logic             match;
	logic             last_addr;

	// Write intervals, read one entry per cycle for the scan
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1 <= mem[addr_q];
	end

	// Entry agrees with the prefix above this bit and has this bit clear
	always_comb begin
		hi_mask   = FULL32 << bit_q;
		match     = ((rd_s1 & hi_mask) == pfx_q);
		last_addr = (CNT_W'(addr_q) == n_q - CNT_W'(1));
	end

	// Next state of the radix select
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEL_IDLE:   if (sel_cmd.start) state_d = SEL_SCAN;
			SEL_SCAN:   if (last_addr) state_d = SEL_DRAIN;
			SEL_DRAIN:  state_d = SEL_UPDATE;
			SEL_UPDATE: state_d = (bit_q == 5'd0) ? SEL_IDLE : SEL_SCAN;
			default:    state_d = SEL_IDLE;
		endcase
	end

	// Sweep the ring once per bit, fix one result bit per sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEL_IDLE;
			bit_q   <= '0;
			addr_q  <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			k_q     <= '0;
			pfx_q   <= '0;
			done_q  <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			vld_s1  <= (state_q == SEL_SCAN);
			if (vld_s1 && match) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				SEL_IDLE: begin
					if (sel_cmd.start) begin
						bit_q  <= 5'd31;
						addr_q <= '0;
						cnt_q  <= '0;
						n_q    <= sel_cmd.count;
						k_q    <= sel_cmd.rank;
						pfx_q  <= '0;
					end
				end
				SEL_SCAN: begin
					if (!last_addr) begin
						addr_q <= addr_q + 1'b1;
					end
				end
				SEL_DRAIN: begin
				end
				SEL_UPDATE: begin
					if (CNT_W'(k_q) >= cnt_q) begin
						pfx_q[bit_q] <= 1'b1;
						k_q          <= k_q - IDX_W'(cnt_q);
					end
					cnt_q  <= '0;
					addr_q <= '0;
					if (bit_q == 5'd0) begin
						done_q <= 1'b1;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Drive status
	always_comb begin
		sel_sts.done  = done_q;
		sel_sts.value = pfx_q;
	end

endmodule

/* sim/tb_smon_ifs.sv */
`timescale 1ns / 1ps
// Channel definitions come from the RTL interface files; this file only
// holds the beat type used by the stimulus queue.
package tb_smon_pkg;
	import smon_pkg::*;

	typedef struct {
		logic [1:0]  opcode;
		logic [31:0] sequence_number;
		logic [63:0] time_us;
		bit          quiet;
	} stim_beat_t;
endpackage

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
	import smon_pkg::*;
	import tb_smon_pkg::*;

	localparam int LIMIT_CYCLES = 200000000;

	logic clk;
	logic arst_n;

	smon_req_if req();
	smon_rsp_if rsp();

	stream_gap_and_jitter_monitor u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	// Predictor state
	logic [31:0] mdl_prev_seq;
	bit          mdl_seq_seen;
	logic [63:0] mdl_prev_time;
	bit          mdl_time_seen;
	logic [63:0] mdl_window_start;
	logic [31:0] mdl_ring [RING_DEPTH];
	int          mdl_cursor;
	int          mdl_fill;
	logic [31:0] mdl_received;
	logic [31:0] mdl_dropped;

	stim_beat_t  pending_beats[$];
	smon_rsp_t   expected_snapshots[$];
	int          mismatch_count;
	bit          quiet_phase;
	bit          req_fire;
	int          req_gap;
	int          rsp_stall;
	longint      cycle_count;

	always #10 clk = ~clk;

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? FULL32 : s[31:0];
	endfunction

	function automatic void clear_stats();
		mdl_prev_seq = '0;
		mdl_seq_seen = 0;
		mdl_prev_time = '0;
		mdl_time_seen = 0;
		mdl_window_start = '0;
		for (int i = 0; i < RING_DEPTH; i++)
			mdl_ring[i] = '0;
		mdl_cursor = 0;
		mdl_fill = 0;
		mdl_received = '0;
		mdl_dropped = '0;
	endfunction

	function automatic void take_packet(logic [31:0] seq, logic [63:0] t);
		logic [31:0] seq_dist;
		logic [63:0] diff;
		if (mdl_seq_seen) begin
			seq_dist = seq - mdl_prev_seq;
			if (seq_dist > 1 && seq_dist < GAP_LIMIT)
				mdl_dropped = sat_add(mdl_dropped, seq_dist - 1);
		end
		mdl_prev_seq = seq;
		mdl_seq_seen = 1;
		if (mdl_time_seen) begin
			diff = (t >= mdl_prev_time) ? t - mdl_prev_time : '0;
			mdl_ring[mdl_cursor] = (diff > 64'(FULL32)) ? FULL32 : diff[31:0];
			mdl_cursor = (mdl_cursor + 1) % RING_DEPTH;
			if (mdl_fill < RING_DEPTH)
				mdl_fill++;
		end else begin
			mdl_time_seen = 1;
			mdl_window_start = t;
		end
		mdl_prev_time = t;
		mdl_received = sat_add(mdl_received, 1);
	endfunction

	function automatic smon_rsp_t snapshot(logic [63:0] now);
		smon_rsp_t r;
		logic [31:0] vals[$];
		logic [127:0] q;
		int n;
		r = '0;
		r.received_count = mdl_received;
		r.dropped_count = mdl_dropped;
		r.sequence_seen = mdl_seq_seen;
		r.last_sequence_number = mdl_prev_seq;
		if (mdl_time_seen && now > mdl_window_start) begin
			q = (128'(mdl_received) * 128'd256000000) / 128'(now - mdl_window_start);
			r.rate_valid = 1;
			r.rate_hz_q8 = (q > 128'(FULL32)) ? FULL32 : q[31:0];
		end
		n = mdl_fill;
		if (n > 0) begin
			for (int i = 0; i < n; i++)
				vals.insert(vals.size(), mdl_ring[i]);
			vals.sort();
			r.intervals_valid = 1;
			r.median_interval_us = vals[((n - 1) * 50) / 100];
			r.p95_interval_us = vals[((n - 1) * 95) / 100];
			r.p99_interval_us = vals[((n - 1) * 99) / 100];
			r.max_interval_us = vals[n - 1];
		end
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
		mismatch_count++;
	endtask

	// Driver: present beats at the falling edge, with random idle bursts
	always @(negedge clk) begin
		if (arst_n) begin
			// hold the beat until it was taken at the last rising edge
			if (!req.valid || req_fire) begin
				if (req_gap > 0) begin
					req.valid <= 1'b0;
					req_gap <= req_gap - 1;
				end else if (pending_beats.size() > 0
						&& !(pending_beats[0].quiet && expected_snapshots.size() > 0)) begin
					req.valid <= 1'b1;
					req.data.opcode <= pending_beats[0].opcode;
					req.data.sequence_number <= pending_beats[0].sequence_number;
					req.data.time_us <= pending_beats[0].time_us;
					void'(pending_beats.pop_front());
					if (!quiet_phase && $urandom_range(0, 9) == 0)
						req_gap <= $urandom_range(1, 18);
				end else begin
					req.valid <= 1'b0;
				end
			end
			// hold rsp in random stall bursts
			if (rsp_stall > 0) begin
				rsp.ready <= 1'b0;
				rsp_stall <= rsp_stall - 1;
			end else begin
				rsp.ready <= 1'b1;
				if (!quiet_phase && $urandom_range(0, 7) == 0)
					rsp_stall <= $urandom_range(1, 18);
			end
		end
	end

	// Monitor: predict on accepted req beats, check rsp beats
	always @(posedge clk) begin
		smon_rsp_t want;
		smon_rsp_t got;
		req_fire <= req.valid && req.ready;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (req.valid && req.ready) begin
				case (req.data.opcode)
					OP_ACCEPT: take_packet(req.data.sequence_number, req.data.time_us);
					OP_QUERY:  expected_snapshots.insert(expected_snapshots.size(),
						snapshot(req.data.time_us));
					OP_CLEAR:  clear_stats();
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (expected_snapshots.size() == 0) begin
					report("unexpected beat", got.received_count, '0);
				end else begin
					want = expected_snapshots.pop_front();
					if (got.received_count !== want.received_count)
						report("received_count", got.received_count, want.received_count);
					if (got.dropped_count !== want.dropped_count)
						report("dropped_count", got.dropped_count, want.dropped_count);
					if (got.sequence_seen !== want.sequence_seen)
						report("sequence_seen", 32'(got.sequence_seen), 32'(want.sequence_seen));
					if (got.last_sequence_number !== want.last_sequence_number)
						report("last_sequence_number", got.last_sequence_number,
							want.last_sequence_number);
					if (got.rate_valid !== want.rate_valid)
						report("rate_valid", 32'(got.rate_valid), 32'(want.rate_valid));
					if (got.rate_hz_q8 !== want.rate_hz_q8)
						report("rate_hz_q8", got.rate_hz_q8, want.rate_hz_q8);
					if (got.intervals_valid !== want.intervals_valid)
						report("intervals_valid", 32'(got.intervals_valid),
							32'(want.intervals_valid));
					if (got.median_interval_us !== want.median_interval_us)
						report("median_interval_us", got.median_interval_us,
							want.median_interval_us);
					if (got.p95_interval_us !== want.p95_interval_us)
						report("p95_interval_us", got.p95_interval_us, want.p95_interval_us);
					if (got.p99_interval_us !== want.p99_interval_us)
						report("p99_interval_us", got.p99_interval_us, want.p99_interval_us);
					if (got.max_interval_us !== want.max_interval_us)
						report("max_interval_us", got.max_interval_us, want.max_interval_us);
				end
			end
			if (cycle_count > LIMIT_CYCLES) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic add_beat(logic [1:0] op, logic [31:0] seq, logic [63:0] t);
		stim_beat_t b;
		b.opcode = op;
		b.sequence_number = seq;
		b.time_us = t;
		b.quiet = 0;
		pending_beats.insert(pending_beats.size(), b);
	endtask

	// Random 64-bit value over the whole range
	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [31:0] seq;
		logic [63:0] t;
		int pick;
		clk = 0;
		arst_n = 0;
		req.valid = 0;
		req.data = '0;
		rsp.ready = 0;
		mismatch_count = 0;
		quiet_phase = 0;
		req_gap = 0;
		rsp_stall = 0;
		cycle_count = 0;
		clear_stats();

		// directed: empty query, extremes, backward time and sequence, opcode 3
		add_beat(OP_QUERY, '0, '0);
		add_beat(OP_ACCEPT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
		add_beat(OP_QUERY, '0, 64'hFFFF_FFFF_FFFF_FFF0);
		add_beat(OP_QUERY, '0, 64'hFFFF_FFFF_FFFF_FFFF);
		add_beat(OP_ACCEPT, 32'h0000_0005, 64'h0000_0000_0000_0010);
		add_beat(OP_ACCEPT, 32'h0000_0004, 64'h0000_0000_0000_0000);
		add_beat(OP_ACCEPT, 32'h8000_0004, 64'h0000_0001_0000_0000);
		add_beat(OP_ACCEPT, 32'h8000_0005, 64'h0000_0002_0000_0001);
		add_beat(OP_ACCEPT, 32'h0000_0004, 64'h0000_0002_0000_0001);
		add_beat(OP_ACCEPT, 32'h7FFF_FFFF, 64'h0000_0002_0000_0002);
		add_beat(2'd3, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_beat(OP_QUERY, '0, 64'h0000_0002_0000_0000);
		add_beat(OP_QUERY, '0, 64'h0000_0000_0000_0001);
		add_beat(OP_CLEAR, '0, '0);
		add_beat(OP_QUERY, '0, 64'h10);
		add_beat(OP_ACCEPT, 32'h0, 64'h0);
		add_beat(OP_ACCEPT, 32'h7FFF_FFFF, 64'h1);
		add_beat(OP_ACCEPT, 32'hFFFF_FFFD, 64'h2);
		add_beat(OP_QUERY, '0, 64'h1);
		add_beat(OP_QUERY, '0, 64'h2);

		// random: packet runs with mostly small gaps, sparse queries, rare clears
		seq = $urandom();
		t = 64'($urandom_range(0, 1000));
		for (int i = 0; i < 1080; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 84) begin
				case ($urandom_range(0, 9))
					0: seq = $urandom();
					1: seq = seq - $urandom_range(0, 3);
					2, 3: seq = seq + $urandom_range(2, 40);
					default: seq = seq + 1;
				endcase
				case ($urandom_range(0, 15))
					0: t = rand64();
					1: t = t - $urandom_range(0, 500);
					2: t = t + 64'($urandom()) + 64'h1_0000_0000;
					default: t = t + $urandom_range(0, 2000);
				endcase
				add_beat(OP_ACCEPT, seq, t);
			end else if (pick < 98) begin
				if ($urandom_range(0, 7) == 0)
					add_beat(OP_QUERY, $urandom(), rand64());
				else
					add_beat(OP_QUERY, $urandom(), t + $urandom_range(0, 5000));
			end else if (pick < 99) begin
				add_beat(OP_CLEAR, $urandom(), rand64());
			end else begin
				add_beat(2'd3, $urandom(), rand64());
			end
		end
		// a full ring and beyond, then query
		for (int i = 0; i < 300; i++) begin
			t = t + $urandom_range(0, 3000);
			seq = seq + 1;
			add_beat(OP_ACCEPT, seq, t);
		end
		add_beat(OP_QUERY, '0, t + 10);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		wait (pending_beats.size() < 40);
		quiet_phase = 1;
		wait (pending_beats.size() == 0);
		@(posedge clk);
		while (req.valid || expected_snapshots.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && expected_snapshots.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
